[rtl/crb_pkg.sv]
package crb_pkg;

   localparam int SIZE_W    = 48;
   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 48;
   localparam int RA_W      = 53;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [RA_W-1:0] RA_MAX = {RA_W{1'b1}};
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   localparam logic [31:0] TIMEOUT_RESET   = 32'd500000;
   localparam logic [31:0] THRESHOLD_RESET = 32'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SIZE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_US       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCESS_THRESHOLD = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0]  prev_limit;
      logic [SIZE_W-1:0]  load_bytes;
      logic [COUNT_W-1:0] hit_count;
      logic [TIME_W-1:0]  now_us;
      logic               last_shard;
   } crb_req_type;

   typedef struct packed {
      logic [5:0]        shard_index;
      logic [SIZE_W-1:0] new_limit;
      logic              read_ahead_allowed;
      logic              rebalanced;
      logic              last_result;
   } crb_rsp_type;

   typedef struct packed {
      logic start;
      logic mul_mode;
   } crb_unit_ctl_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_MUL,
      UNIT_DIV,
      UNIT_DONE
   } crb_unit_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RA_ACC,
      ST_DECIDE,
      ST_STATUS,
      ST_P1_FETCH,
      ST_P1_START,
      ST_P1_WAIT,
      ST_EXTRA,
      ST_R_CHECK,
      ST_R_DIVW,
      ST_R_FETCH,
      ST_R_UPD,
      ST_O_FETCH,
      ST_O_SEND
   } crb_state_type;

endpackage

[rtl/cache_share_rebalancer.sv]
// A non-final shard item is taken whenever the block is idle. A final item without a rebalance
// gives its status result through the RA_ACC, DECIDE and STATUS states. A rebalance runs each
// shard through a multiply and then a divide in the shared multiply-divide unit, then spreading
// passes, then sends one result per shard, each fetched before it is sent; the input stays
// stalled until the last result of the round is taken. Synchronous active-high reset clears
// control state and loads register reset values; the shard stores need no clearing.
module cache_share_rebalancer #(
   parameter int MAX_SHARDS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  crb_pkg::crb_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output crb_pkg::crb_rsp_type                  rsp_data,
   input  logic                                  csr_we,
   input  logic [crb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [crb_pkg::CSR_W-1:0]             csr_wdata
);
   import crb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SHARDS + 1);
   localparam int IDX_W  = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int SUM_W  = SIZE_W + CNT_W;
   localparam int ASUM_W = COUNT_W + CNT_W;
   localparam int EXT_W  = SUM_W + 1;
   localparam int PROD_W = SIZE_W + SUM_W;

   crb_state_type         state_ff, state_in;
   logic [SIZE_W-1:0]     total_ff, total_in;
   logic [31:0]           timeout_ff, timeout_in;
   logic [31:0]           thresh_ff, thresh_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      lsum_ff, lsum_in;
   logic [ASUM_W-1:0]     asum_ff, asum_in;
   logic [TIME_W-1:0]     last_reb_ff, last_reb_in;
   logic                  flag_ff, flag_in;
   logic [RA_W-1:0]       ra_ff, ra_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SIZE_W:0]       base_ff, base_in;
   logic [SUM_W-1:0]      sum_new_ff, sum_new_in;
   logic signed [EXT_W-1:0] extra_ff, extra_in;
   logic signed [EXT_W-1:0] delta_ff, delta_in;

   logic                  req_accept;
   logic                  in_we;
   logic [SIZE_W-1:0]     old_rd, loaded_rd, new_rd;
   logic                  new_we;
   logic [SIZE_W-1:0]     new_wdata;
   crb_unit_ctl_type      unit_ctl;
   logic [SUM_W-1:0]      unit_b;
   logic [SIZE_W-1:0]     unit_d;
   logic                  unit_done;
   logic [PROD_W-1:0]     unit_q;
   logic [SUM_W-1:0]      extra_mag;
   logic                  last_idx;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_we      = req_accept && (count_ff < CNT_W'(MAX_SHARDS));
   assign last_idx   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign extra_mag  = extra_ff[EXT_W-1] ? SUM_W'(-extra_ff) : SUM_W'(extra_ff);
   assign unit_b     = unit_ctl.mul_mode ? lsum_ff : extra_mag;
   assign unit_d     = unit_ctl.mul_mode ? total_ff : SIZE_W'(count_ff);

   crb_ram #(.DATA_W(SIZE_W), .DEPTH(MAX_SHARDS), .ADDR_W(IDX_W)) u_old_store (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.prev_limit),
      .rd_addr (idx_ff),
      .rd_data (old_rd)
   );

   crb_ram #(.DATA_W(SIZE_W), .DEPTH(MAX_SHARDS), .ADDR_W(IDX_W)) u_loaded_store (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.load_bytes),
      .rd_addr (idx_ff),
      .rd_data (loaded_rd)
   );

   crb_ram #(.DATA_W(SIZE_W), .DEPTH(MAX_SHARDS), .ADDR_W(IDX_W)) u_new_store (
      .clock   (clock),
      .wr_en   (new_we),
      .wr_addr (idx_ff),
      .wr_data (new_wdata),
      .rd_addr (idx_ff),
      .rd_data (new_rd)
   );

   crb_muldiv #(.B_W(SUM_W), .PROD_W(PROD_W)) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .op_a     (old_rd),
      .op_b     (unit_b),
      .divisor  (unit_d),
      .done     (unit_done),
      .quotient (unit_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         total_ff    <= '0;
         timeout_ff  <= TIMEOUT_RESET;
         thresh_ff   <= THRESHOLD_RESET;
         count_ff    <= '0;
         lsum_ff     <= '0;
         asum_ff     <= '0;
         last_reb_ff <= '0;
         flag_ff     <= 1'b1;
         ra_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         timeout_ff  <= timeout_in;
         thresh_ff   <= thresh_in;
         count_ff    <= count_in;
         lsum_ff     <= lsum_in;
         asum_ff     <= asum_in;
         last_reb_ff <= last_reb_in;
         flag_ff     <= flag_in;
         ra_ff       <= ra_in;
      end
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      base_ff    <= base_in;
      sum_new_ff <= sum_new_in;
      extra_ff   <= extra_in;
      delta_ff   <= delta_in;
   end

   always_comb begin
      logic [RA_W+2:0]           ra_sum;
      logic [RA_W+3:0]           ra_x10;
      logic [RA_W+3:0]           tot_x9;
      logic [TIME_W:0]           deadline;
      logic                      quiet;
      logic [SIZE_W:0]           diff;
      logic [SIZE_W-1:0]         v;
      logic [EXT_W-1:0]          qd;
      logic signed [EXT_W:0]     cur;
      logic signed [EXT_W:0]     s;
      logic signed [EXT_W-1:0]   extra_next;

      state_in    = state_ff;
      total_in    = total_ff;
      timeout_in  = timeout_ff;
      thresh_in   = thresh_ff;
      count_in    = count_ff;
      lsum_in     = lsum_ff;
      asum_in     = asum_ff;
      last_reb_in = last_reb_ff;
      flag_in     = flag_ff;
      ra_in       = ra_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      sum_new_in  = sum_new_ff;
      extra_in    = extra_ff;
      delta_in    = delta_ff;
      new_we      = 1'b0;
      new_wdata   = '0;
      unit_ctl    = '0;
      rsp_valid   = 1'b0;
      rsp_data    = '0;
      rsp_data.read_ahead_allowed = flag_ff;

      ra_sum   = (RA_W+3)'(ra_ff) + (RA_W+3)'(lsum_ff);
      ra_x10   = ((RA_W+4)'(ra_ff) << 3) + ((RA_W+4)'(ra_ff) << 1);
      tot_x9   = ((RA_W+4)'(total_ff) << 3) + (RA_W+4)'(total_ff);
      deadline = (TIME_W+1)'(last_reb_ff) + (TIME_W+1)'(timeout_ff);
      quiet    = ((TIME_W+1)'(now_ff) < deadline) && (asum_ff < ASUM_W'(thresh_ff));
      diff     = base_ff - (SIZE_W+1)'(unit_q);
      v        = (unit_q >= PROD_W'(base_ff)) ? '0 :
                 (diff[SIZE_W] ? SIZE_MAX : diff[SIZE_W-1:0]);
      qd       = unit_q[EXT_W-1:0];
      cur      = $signed((EXT_W+1)'(new_rd));
      s        = cur + (EXT_W+1)'(delta_ff);
      extra_next = extra_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_SIZE:       total_in   = csr_wdata[SIZE_W-1:0];
            CSR_TIMEOUT_US:       timeout_in = csr_wdata[31:0];
            CSR_ACCESS_THRESHOLD: thresh_in  = csr_wdata[31:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_we) begin
               count_in = count_ff + CNT_W'(1);
               lsum_in  = lsum_ff + SUM_W'(req_data.load_bytes);
               asum_in  = asum_ff + ASUM_W'(req_data.hit_count);
            end
            if (req_accept && req_data.last_shard) begin
               now_in   = req_data.now_us;
               state_in = ST_RA_ACC;
            end
         end
         ST_RA_ACC: begin
            if (flag_ff) begin
               ra_in = (ra_sum > (RA_W+3)'(RA_MAX)) ? RA_MAX : ra_sum[RA_W-1:0];
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (flag_ff) begin
               flag_in = !(ra_x10 >= tot_x9);
            end
            if (quiet) begin
               state_in = ST_STATUS;
            end else begin
               last_reb_in = now_ff;
               if (total_ff == '0 || count_ff == '0) begin
                  state_in = ST_STATUS;
               end else begin
                  idx_in     = '0;
                  sum_new_in = '0;
                  state_in   = ST_P1_FETCH;
               end
            end
         end
         ST_STATUS: begin
            rsp_valid            = 1'b1;
            rsp_data.last_result = 1'b1;
            if (!rsp_stall) begin
               count_in = '0;
               lsum_in  = '0;
               asum_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_P1_FETCH: begin
            state_in = ST_P1_START;
         end
         ST_P1_START: begin
            unit_ctl.start    = 1'b1;
            unit_ctl.mul_mode = 1'b1;
            base_in  = (SIZE_W+1)'(old_rd) + (SIZE_W+1)'(loaded_rd);
            state_in = ST_P1_WAIT;
         end
         ST_P1_WAIT: begin
            unit_ctl.mul_mode = 1'b1;
            if (unit_done) begin
               new_we     = 1'b1;
               new_wdata  = v;
               sum_new_in = sum_new_ff + SUM_W'(v);
               if (last_idx) begin
                  state_in = ST_EXTRA;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_P1_FETCH;
               end
            end
         end
         ST_EXTRA: begin
            extra_in = $signed(EXT_W'(total_ff)) - $signed(EXT_W'(sum_new_ff));
            state_in = ST_R_CHECK;
         end
         ST_R_CHECK: begin
            if (extra_ff == '0) begin
               idx_in   = '0;
               state_in = ST_O_FETCH;
            end else begin
               unit_ctl.start = 1'b1;
               state_in       = ST_R_DIVW;
            end
         end
         ST_R_DIVW: begin
            if (unit_done) begin
               // A share that rounds to nothing still moves one byte per shard.
               if (qd == '0) begin
                  delta_in = extra_ff[EXT_W-1] ? -EXT_W'(1) : EXT_W'(1);
               end else begin
                  delta_in = extra_ff[EXT_W-1] ? -$signed(qd) : $signed(qd);
               end
               idx_in   = '0;
               state_in = ST_R_FETCH;
            end
         end
         ST_R_FETCH: begin
            state_in = ST_R_UPD;
         end
         ST_R_UPD: begin
            new_we = 1'b1;
            if (!s[EXT_W]) begin
               new_wdata  = s[SIZE_W-1:0];
               extra_next = extra_ff - delta_ff;
            end else begin
               new_wdata  = '0;
               extra_next = extra_ff + EXT_W'(cur);
            end
            extra_in = extra_next;
            if (last_idx || extra_next == '0) begin
               state_in = ST_R_CHECK;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_R_FETCH;
            end
         end
         ST_O_FETCH: begin
            state_in = ST_O_SEND;
         end
         ST_O_SEND: begin
            rsp_valid            = 1'b1;
            rsp_data.shard_index = 6'(idx_ff);
            rsp_data.new_limit   = new_rd;
            rsp_data.rebalanced  = 1'b1;
            rsp_data.last_result = last_idx;
            if (!rsp_stall) begin
               if (last_idx) begin
                  count_in = '0;
                  lsum_in  = '0;
                  asum_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_O_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

[rtl/crb_ram.sv]
module crb_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;
endmodule

[rtl/crb_muldiv.sv]
module crb_muldiv #(
   parameter int B_W    = 53,
   parameter int PROD_W = 101
) (
   input  logic                               clock,
   input  logic                               reset,
   input  crb_pkg::crb_unit_ctl_type          ctl,
   input  logic [crb_pkg::SIZE_W-1:0]         op_a,
   input  logic [B_W-1:0]                     op_b,
   input  logic [crb_pkg::SIZE_W-1:0]         divisor,
   output logic                               done,
   output logic [PROD_W-1:0]                  quotient
);
   import crb_pkg::*;

   localparam int STEP_W = $clog2(PROD_W + 1);

   crb_unit_state_type ustate_ff, ustate_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0]  a_ff, a_in;
   logic [B_W-1:0]     b_ff, b_in;
   logic [SIZE_W-1:0]  d_ff, d_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= UNIT_IDLE;
      end else begin
         ustate_ff <= ustate_in;
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      step_ff <= step_in;
   end

   always_comb begin
      logic [SIZE_W:0] trial;
      logic [SIZE_W:0] diff;
      logic            ge;
      ustate_in = ustate_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      d_in      = d_ff;
      step_in   = step_ff;
      done      = 1'b0;
      trial     = {rem_ff, acc_ff[PROD_W-1]};
      ge        = (trial >= {1'b0, d_ff});
      diff      = trial - {1'b0, d_ff};
      unique case (ustate_ff)
         UNIT_IDLE: begin
            if (ctl.start) begin
               a_in   = op_a;
               b_in   = op_b;
               d_in   = divisor;
               rem_in = '0;
               if (ctl.mul_mode) begin
                  acc_in    = '0;
                  step_in   = STEP_W'(B_W);
                  ustate_in = UNIT_MUL;
               end else begin
                  acc_in    = PROD_W'(op_b);
                  step_in   = STEP_W'(PROD_W);
                  ustate_in = UNIT_DIV;
               end
            end
         end
         UNIT_MUL: begin
            // Shift-and-add, most significant multiplier bit first.
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0} + (b_ff[B_W-1] ? PROD_W'(a_ff) : '0);
            b_in    = {b_ff[B_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               step_in   = STEP_W'(PROD_W);
               rem_in    = '0;
               ustate_in = UNIT_DIV;
            end
         end
         UNIT_DIV: begin
            // Restoring division: quotient bits shift in as dividend bits shift out.
            rem_in  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            acc_in  = {acc_ff[PROD_W-2:0], ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               ustate_in = UNIT_DONE;
            end
         end
         UNIT_DONE: begin
            done      = 1'b1;
            ustate_in = UNIT_IDLE;
         end
         default: begin
            ustate_in = UNIT_IDLE;
         end
      endcase
   end

   assign quotient = acc_ff;
endmodule
